@@ rtl/mcps_pkg.sv @@
package mcps_pkg;

   // Item kinds carried in tuser
   typedef enum logic [1:0] {
      KIND_TICK   = 2'd0,
      KIND_TIMING = 2'd1,
      KIND_MODE   = 2'd2,
      KIND_SPARE  = 2'd3
   } kind_type;

   // Sequencer states
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SWEEP,
      ST_DONE
   } state_type;

   // Field widths of the stream words
   localparam int unsigned KIND_BITS    = 2;
   localparam int unsigned CHAN_BITS    = 5;
   localparam int unsigned TICKS_BITS   = 24;
   localparam int unsigned MASK_BITS    = 28;
   localparam int unsigned REQ_DATA_BITS = 56;
   localparam int unsigned RSP_DATA_BITS = 56;

   // Per-channel timing after reset: 20 ms period, 1 ms pulse at 100 kHz ticks
   localparam logic [TICKS_BITS-1:0] RESET_PERIOD = 24'd2000;
   localparam logic [TICKS_BITS-1:0] RESET_WIDTH  = 24'd100;

endpackage

@@ rtl/multi_channel_pwm_scheduler_unit.sv @@
// Per-tick PWM scheduler for up to CHANNELS pins. A tick word (tuser kind 0) is
// answered by one result word holding a set mask and a clear mask; timing and
// mode words (kinds 1 and 2) update one channel in the cycle they are taken and
// answer nothing. A timing word with zero period or width above period, a
// set-up word for a channel of CHANNELS or above, and kind 3 are dropped. A tick
// is handled in order: the accepting cycle, then a sweep in which one shared
// add and compare unit visits the channels one at a time, then the move of the
// masks to the output register, delayed while a previous result is still held
// there. The input is not ready from the tick until the masks are loaded.
// Times wrap modulo 2**TIME_BITS.
module multi_channel_pwm_scheduler_unit
   import mcps_pkg::*;
#(
   parameter int unsigned CHANNELS  = 28,
   parameter int unsigned TIME_BITS = 32
) (
   input  logic                     clock,
   input  logic                     reset,
   // request stream
   input  logic                     req_tvalid,
   output logic                     req_tready,
   // fields from bit 0: channel[4:0], period_ticks[23:0], width_ticks[23:0],
   // pwm_on, two zero bits
   input  logic [REQ_DATA_BITS-1:0] req_tdata,
   // fields from bit 0: kind[1:0]
   input  logic [KIND_BITS-1:0]     req_tuser,
   // response stream
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   // fields from bit 0: set_mask[27:0], clear_mask[27:0]
   output logic [RSP_DATA_BITS-1:0] rsp_tdata
);

   localparam int unsigned IDX_BITS = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam logic [IDX_BITS-1:0] LAST_IDX = IDX_BITS'(CHANNELS - 1);
   localparam logic [CHAN_BITS:0] CHAN_LIMIT = (CHAN_BITS + 1)'(CHANNELS);

   // Unpack request word
   logic [CHAN_BITS-1:0]  req_channel;
   logic [TICKS_BITS-1:0] req_period_ticks;
   logic [TICKS_BITS-1:0] req_width_ticks;
   logic                  req_pwm_on;
   logic [KIND_BITS-1:0]  req_kind;

   assign req_channel      = req_tdata[CHAN_BITS-1:0];
   assign req_period_ticks = req_tdata[CHAN_BITS +: TICKS_BITS];
   assign req_width_ticks  = req_tdata[CHAN_BITS + TICKS_BITS +: TICKS_BITS];
   assign req_pwm_on       = req_tdata[CHAN_BITS + 2*TICKS_BITS];
   assign req_kind         = req_tuser;

   // Per-channel state
   logic [TIME_BITS-1:0]  next_start_ff [CHANNELS];
   logic [TIME_BITS-1:0]  next_end_ff   [CHANNELS];
   logic [TICKS_BITS-1:0] period_ff     [CHANNELS];
   logic [TICKS_BITS-1:0] width_ff      [CHANNELS];
   logic [CHANNELS-1:0]   active_ff;
   logic [CHANNELS-1:0]   mode_ff;

   // Sequencer and shared state
   state_type             state_ff, state_in;
   logic [IDX_BITS-1:0]   idx_ff, idx_in;
   logic [TIME_BITS-1:0]  tick_ff, tick_in;
   logic [CHANNELS-1:0]   set_acc_ff, clr_acc_ff;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [MASK_BITS-1:0]  set_out_ff, clr_out_ff;

   // Control decoded from the handshake and sequencer
   logic req_take;
   logic take_tick;
   logic take_timing;
   logic take_mode;
   logic chan_ok;
   logic sweep_step;
   logic sweep_last;
   logic load_rsp;

   // Shared channel unit outputs
   logic                 start_hit;
   logic                 end_hit;
   logic                 ch_begin;
   logic                 ch_fall;
   logic                 ch_stop;
   logic [TIME_BITS-1:0] new_start;
   logic [TIME_BITS-1:0] new_end;

   assign req_tready  = (state_ff == ST_IDLE);
   assign req_take    = req_tvalid && req_tready;
   assign chan_ok     = {1'b0, req_channel} < CHAN_LIMIT;
   assign take_tick   = req_take && (req_kind == KIND_TICK);
   assign take_timing = req_take && (req_kind == KIND_TIMING) && chan_ok
                        && (req_period_ticks != '0)
                        && (req_width_ticks <= req_period_ticks);
   assign take_mode   = req_take && (req_kind == KIND_MODE) && chan_ok;
   assign sweep_step  = (state_ff == ST_SWEEP);
   assign sweep_last  = sweep_step && (idx_ff == LAST_IDX);
   assign load_rsp    = (state_ff == ST_DONE) && (!rsp_valid_ff || rsp_tready);

   // Evaluate the channel under the sweep index
   always_comb begin
      start_hit = (tick_ff == next_start_ff[idx_ff]);
      end_hit   = (tick_ff == next_end_ff[idx_ff]);
      new_start = tick_ff + TIME_BITS'(period_ff[idx_ff]);
      new_end   = tick_ff + TIME_BITS'(width_ff[idx_ff]);
      ch_begin  = mode_ff[idx_ff] && (start_hit || !active_ff[idx_ff]);
      ch_fall   = !ch_begin && end_hit && active_ff[idx_ff]
                  && (next_end_ff[idx_ff] != next_start_ff[idx_ff]);
      ch_stop   = !ch_begin && !ch_fall && !mode_ff[idx_ff] && start_hit
                  && active_ff[idx_ff];
   end

   // Next state, sweep index, counter and output valid
   always_comb begin
      state_in     = state_ff;
      idx_in       = idx_ff;
      tick_in      = tick_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      case (state_ff)
         ST_IDLE: begin
            if (take_tick) begin
               state_in = ST_SWEEP;
               idx_in   = '0;
            end
         end
         ST_SWEEP: begin
            if (sweep_last) begin
               state_in = ST_DONE;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end
         ST_DONE: begin
            if (load_rsp) begin
               state_in     = ST_IDLE;
               tick_in      = tick_ff + 1'b1;
               rsp_valid_in = 1'b1;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Hold sequencer registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         idx_ff       <= '0;
         tick_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         tick_ff      <= tick_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Update per-channel state from set-up words and the sweep
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < CHANNELS; i++) begin
            next_start_ff[i] <= '0;
            next_end_ff[i]   <= '0;
            period_ff[i]     <= RESET_PERIOD;
            width_ff[i]      <= RESET_WIDTH;
         end
         active_ff <= '0;
         mode_ff   <= '0;
      end else begin
         if (take_timing) begin
            period_ff[req_channel[IDX_BITS-1:0]] <= req_period_ticks;
            width_ff[req_channel[IDX_BITS-1:0]]  <= req_width_ticks;
         end
         if (take_mode) begin
            mode_ff[req_channel[IDX_BITS-1:0]] <= req_pwm_on;
         end
         if (sweep_step && ch_begin) begin
            active_ff[idx_ff]     <= 1'b1;
            next_start_ff[idx_ff] <= new_start;
            next_end_ff[idx_ff]   <= new_end;
         end else if (sweep_step && ch_stop) begin
            active_ff[idx_ff] <= 1'b0;
         end
      end
   end

   // Accumulate masks; a zero width starts a period low
   always_ff @(posedge clock) begin
      if (take_tick) begin
         set_acc_ff <= '0;
         clr_acc_ff <= '0;
      end else if (sweep_step) begin
         set_acc_ff[idx_ff] <= ch_begin && (width_ff[idx_ff] != '0);
         clr_acc_ff[idx_ff] <= (ch_begin && (width_ff[idx_ff] == '0)) || ch_fall;
      end
   end

   // Move finished masks to the output register
   always_ff @(posedge clock) begin
      if (load_rsp) begin
         set_out_ff <= MASK_BITS'(set_acc_ff);
         clr_out_ff <= MASK_BITS'(clr_acc_ff);
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {clr_out_ff, set_out_ff};

   // A tick word always starts a sweep at channel zero
   assert property (@(posedge clock) disable iff (reset)
      take_tick |=> (state_ff == ST_SWEEP) && (idx_ff == '0))
      else $error("tick word did not start a sweep");

   // The sweep index advances by one each cycle until the last channel
   assert property (@(posedge clock) disable iff (reset)
      (sweep_step && !sweep_last) |=> (idx_ff == $past(idx_ff) + 1'b1))
      else $error("sweep index skipped");

   // The counter holds through a sweep
   assert property (@(posedge clock) disable iff (reset)
      sweep_step |=> $stable(tick_ff))
      else $error("tick counter moved during sweep");

   // Loading a result raises valid and advances the counter by one
   assert property (@(posedge clock) disable iff (reset)
      load_rsp |=> rsp_valid_ff && (tick_ff == $past(tick_ff) + 1'b1))
      else $error("result load lost or counter not advanced");

   // Set-up words leave the counter and output untouched
   assert property (@(posedge clock) disable iff (reset)
      (req_take && !take_tick) |=> (state_ff == ST_IDLE) && $stable(tick_ff))
      else $error("set-up word disturbed the sequencer");

endmodule

@@ verif/tb_multi_channel_pwm_scheduler_unit.sv @@
module tb_multi_channel_pwm_scheduler_unit;
   import mcps_pkg::*;

   localparam int unsigned NUM_CHANNELS = 28;
   localparam int unsigned CYCLE_LIMIT  = 400000;
   localparam int unsigned DRAIN_CYCLES = 64;
   localparam int unsigned RANDOM_WORDS = 950;

   // One expected result word
   typedef struct packed {
      logic [MASK_BITS-1:0] clear_bits;
      logic [MASK_BITS-1:0] set_bits;
   } mask_pair_type;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_tvalid = 1'b0;
   logic                     req_tready;
   logic [REQ_DATA_BITS-1:0] req_tdata = '0;
   logic [KIND_BITS-1:0]     req_tuser = KIND_TICK;
   logic                     rsp_tvalid;
   logic                     rsp_tready = 1'b0;
   logic [RSP_DATA_BITS-1:0] rsp_tdata;

   // Scheduler state as predicted
   logic [31:0]           tick_now;
   logic [31:0]           period_due [NUM_CHANNELS];
   logic [31:0]           pulse_due  [NUM_CHANNELS];
   logic                  chan_running [NUM_CHANNELS];
   logic [TICKS_BITS-1:0] chan_period  [NUM_CHANNELS];
   logic [TICKS_BITS-1:0] chan_width   [NUM_CHANNELS];
   logic                  chan_pwm     [NUM_CHANNELS];

   mask_pair_type pending_masks [$];

   int unsigned error_count   = 0;
   int unsigned cycle_count   = 0;
   int unsigned tick_words    = 0;
   int unsigned setup_words   = 0;
   int unsigned dropped_words = 0;
   int unsigned masks_checked = 0;
   int unsigned set_seen      = 0;
   int unsigned clear_seen    = 0;
   logic        gaps_on       = 1'b1;

   multi_channel_pwm_scheduler_unit DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   // 10-unit clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Abort a hung run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles", cycle_count);
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   // Stall the result side at random
   always @(negedge clock) begin
      if (gaps_on)
         rsp_tready <= ($urandom_range(99) >= 37);
      else
         rsp_tready <= 1'b1;
   end

   task automatic report_mismatch(input string what, input logic [63:0] want,
                                  input logic [63:0] got);
      $display("Mismatch at cycle %0d: %s expected %h got %h", cycle_count, what, want, got);
      error_count++;
   endtask

   task automatic clear_schedule();
      tick_now = '0;
      for (int i = 0; i < NUM_CHANNELS; i++) begin
         period_due[i]   = '0;
         pulse_due[i]    = '0;
         chan_running[i] = 1'b0;
         chan_period[i]  = RESET_PERIOD;
         chan_width[i]   = RESET_WIDTH;
         chan_pwm[i]     = 1'b0;
      end
   endtask

   // Apply one accepted word to the predicted state; queue masks for a tick
   task automatic apply_word(input kind_type kind, input logic [4:0] chan,
                             input logic [TICKS_BITS-1:0] per,
                             input logic [TICKS_BITS-1:0] wid, input logic on);
      mask_pair_type masks;
      logic [31:0] t;
      masks = '0;
      t = tick_now;
      case (kind)
         KIND_TIMING: begin
            if (chan < NUM_CHANNELS && per != 0 && wid <= per) begin
               chan_period[chan] = per;
               chan_width[chan]  = wid;
               setup_words++;
            end else begin
               dropped_words++;
            end
         end
         KIND_MODE: begin
            if (chan < NUM_CHANNELS) begin
               chan_pwm[chan] = on;
               setup_words++;
            end else begin
               dropped_words++;
            end
         end
         KIND_TICK: begin
            for (int i = 0; i < NUM_CHANNELS; i++) begin
               if (chan_pwm[i] && (t == period_due[i] || !chan_running[i])) begin
                  chan_running[i] = 1'b1;
                  period_due[i]   = t + 32'(chan_period[i]);
                  pulse_due[i]    = t + 32'(chan_width[i]);
                  if (pulse_due[i] != t)
                     masks.set_bits[i] = 1'b1;
                  else
                     masks.clear_bits[i] = 1'b1;
               end else if (t == pulse_due[i] && chan_running[i] &&
                            pulse_due[i] != period_due[i]) begin
                  masks.clear_bits[i] = 1'b1;
               end else if (!chan_pwm[i] && t == period_due[i] && chan_running[i]) begin
                  chan_running[i] = 1'b0;
               end
            end
            tick_now = t + 32'd1;
            tick_words++;
            pending_masks.push_back(masks);
         end
         default: dropped_words++;
      endcase
   endtask

   // Offer one word; returns at the falling edge after it is taken
   task automatic send_word(input kind_type kind, input logic [4:0] chan,
                            input logic [TICKS_BITS-1:0] per,
                            input logic [TICKS_BITS-1:0] wid, input logic on);
      while (gaps_on && $urandom_range(99) < 37) begin
         req_tvalid = 1'b0;
         @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tuser  = kind;
      req_tdata  = {2'b00, on, wid, per, chan};
      do @(posedge clock); while (!req_tready);
      apply_word(kind, chan, per, wid, on);
      @(negedge clock);
   endtask

   // Compare each result word with the oldest expectation
   always @(posedge clock) begin
      mask_pair_type want;
      mask_pair_type got;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_tdata;
         if (pending_masks.size() == 0) begin
            report_mismatch("unexpected result word", '0, 64'(got));
         end else begin
            want = pending_masks.pop_front();
            masks_checked++;
            if (want.set_bits != 0)
               set_seen++;
            if (want.clear_bits != 0)
               clear_seen++;
            if (got.set_bits != want.set_bits)
               report_mismatch("set_mask", 64'(want.set_bits), 64'(got.set_bits));
            if (got.clear_bits != want.clear_bits)
               report_mismatch("clear_mask", 64'(want.clear_bits), 64'(got.clear_bits));
         end
      end
   end

   // Field extremes and words the block must drop
   task automatic test_setup_extremes();
      send_word(KIND_TIMING, 5'd0, 24'hFFFFFF, 24'hFFFFFF, 1'b1);
      send_word(KIND_TIMING, 5'd31, 24'd1, 24'd0, 1'b0);
      send_word(KIND_TIMING, 5'd1, 24'd0, 24'd0, 1'b0);
      send_word(KIND_TIMING, 5'd2, 24'd5, 24'd6, 1'b0);
      send_word(KIND_SPARE, 5'h1F, 24'hFFFFFF, 24'hFFFFFF, 1'b1);
      send_word(KIND_MODE, 5'd30, 24'd0, 24'd0, 1'b1);
   endtask

   // Zero width, width equal to period, one-tick period, default timing
   task automatic test_pulse_shapes();
      send_word(KIND_TIMING, 5'd3, 24'd1, 24'd0, 1'b0);
      send_word(KIND_TIMING, 5'd4, 24'd2, 24'd2, 1'b0);
      send_word(KIND_MODE, 5'd0, 24'd0, 24'd0, 1'b1);
      send_word(KIND_MODE, 5'd3, 24'd0, 24'd0, 1'b1);
      send_word(KIND_MODE, 5'd4, 24'd0, 24'd0, 1'b1);
      send_word(KIND_MODE, 5'd27, 24'd0, 24'd0, 1'b1);
      repeat (4) send_word(KIND_TICK, 5'h1F, 24'hFFFFFF, 24'hFFFFFF, 1'b1);
   endtask

   // Channels leaving PWM mode go idle at their next period start
   task automatic test_mode_exit();
      send_word(KIND_MODE, 5'd4, 24'd0, 24'd0, 1'b0);
      send_word(KIND_MODE, 5'd0, 24'd0, 24'd0, 1'b0);
      repeat (4) send_word(KIND_TICK, 5'd0, 24'd0, 24'd0, 1'b0);
   endtask

   // Mostly ticks and valid short timings, with bad and ignored words mixed in
   task automatic test_random_traffic();
      int unsigned useful;
      int unsigned pick;
      logic [4:0] chan;
      logic [TICKS_BITS-1:0] per;
      logic [TICKS_BITS-1:0] wid;
      useful = 0;
      while (useful < RANDOM_WORDS) begin
         gaps_on = !(useful >= 300 && useful < 450);
         pick = $urandom_range(99);
         chan = 5'($urandom_range(NUM_CHANNELS - 1));
         if (pick < 55) begin
            send_word(KIND_TICK, 5'($urandom), 24'($urandom), 24'($urandom), 1'($urandom));
            useful++;
         end else if (pick < 70) begin
            per = 24'($urandom_range(24, 1));
            wid = 24'($urandom_range(per, 0));
            send_word(KIND_TIMING, chan, per, wid, 1'($urandom));
            useful++;
         end else if (pick < 76) begin
            // full-range timing, valid or not
            send_word(KIND_TIMING, chan, 24'($urandom), 24'($urandom), 1'($urandom));
            useful++;
         end else if (pick < 90) begin
            send_word(KIND_MODE, chan, 24'($urandom), 24'($urandom),
                      ($urandom_range(3) != 0));
            useful++;
         end else if (pick < 95) begin
            send_word(($urandom_range(1) != 0) ? KIND_TIMING : KIND_MODE,
                      5'($urandom_range(31, NUM_CHANNELS)), 24'($urandom_range(24, 1)),
                      24'd0, 1'b1);
            useful++;
         end else begin
            send_word(KIND_SPARE, 5'($urandom), 24'($urandom), 24'($urandom),
                      1'($urandom));
            useful++;
         end
      end
      gaps_on = 1'b1;
   endtask

   initial begin
      int unsigned waited;
      clear_schedule();
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_setup_extremes();
      test_pulse_shapes();
      test_mode_exit();
      test_random_traffic();

      // Drain outstanding results, then let the last sweep settle
      req_tvalid = 1'b0;
      waited = 0;
      while (pending_masks.size() != 0 && waited < 5000) begin
         @(posedge clock);
         waited++;
      end
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (pending_masks.size() != 0)
         report_mismatch("results never delivered", 64'(pending_masks.size()), '0);

      $display("Covered %0d ticks, %0d set-up words applied, %0d words dropped",
               tick_words, setup_words, dropped_words);
      $display("Checked %0d mask words: %0d with rising pins, %0d with falling pins",
               masks_checked, set_seen, clear_seen);
      if (error_count == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
